// ===== sv/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, widths and helpers for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int IDX_W        = 10;
  localparam int KIND_W       = 2;
  localparam int COORD_BITS   = 16;
  localparam int POS_W        = 3 * COORD_BITS;
  localparam int SUM_W        = 48;
  localparam int NRM_W        = 16;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CROSS_W      = PROD_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [NRM_W-1:0]      nrm_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Vertex index to memory address; indexes wrap at the store depth.
  function automatic logic [ADDR_W-1:0] idx_to_addr(logic [IDX_W-1:0] idx);
    logic [ADDR_W+IDX_W-1:0] t;
    t = {{ADDR_W{1'b0}}, idx};
    return t[ADDR_W-1:0];
  endfunction

  function automatic sum_t sat_add(sum_t s, sum_t d);
    logic signed [SUM_W:0] r;
    r = {s[SUM_W-1], s} + {d[SUM_W-1], d};
    if (r[SUM_W] != r[SUM_W-1]) begin
      return r[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return r[SUM_W-1:0];
  endfunction

endpackage

// ===== sv/vna_ram.sv =====
// ----------------------------------------------------------------------------
// vna_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/vna_norm.sv =====
// ----------------------------------------------------------------------------
// vna_norm
// Turns three signed sums into a rounded Q1.14 unit vector: block scaling,
// sum of squares, bit-serial square root and three restoring divides.
// ----------------------------------------------------------------------------
module vna_norm
  import vna_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sum_t sum_x,
  input  sum_t sum_y,
  input  sum_t sum_z,
  output logic done,
  output nrm_t normal_x,
  output nrm_t normal_y,
  output nrm_t normal_z,
  output logic zero_sum
);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DIV   = 6'b010000,
    N_DONE  = 6'b100000
  } nrm_state_t;

  nrm_state_t        state_r;
  logic [SUM_W-1:0]  m_r [3];
  logic              sgn_r [3];
  nrm_t              res_r [3];
  logic              zero_r;
  logic [4:0]        cnt_r;
  logic [1:0]        comp_r;
  logic [59:0]       sq_r;
  logic [61:0]       acc_r;
  logic [61:0]       sqv_r;
  logic [33:0]       rem_r;
  logic [30:0]       root_r;
  logic [30:0]       rdiv_r;
  logic [14:0]       dlo_r;
  logic [14:0]       q_r;

  logic [SUM_W-1:0]  mmax;
  logic [29:0]       sq_op;
  logic [33:0]       rem_w;
  logic [33:0]       trial;
  logic [44:0]       num;
  logic [31:0]       dt;
  logic [14:0]       q_fin;
  logic [SUM_W-1:0]  mag_x, mag_y, mag_z;

  assign mag_x = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
  assign mag_y = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
  assign mag_z = sum_z[SUM_W-1] ? SUM_W'(-sum_z) : SUM_W'(sum_z);

  always_comb begin
    mmax = m_r[0];
    if (m_r[1] > mmax) mmax = m_r[1];
    if (m_r[2] > mmax) mmax = m_r[2];
  end

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_op = m_r[0][29:0];
      2'd1:    sq_op = m_r[1][29:0];
      default: sq_op = m_r[2][29:0];
    endcase
  end

  assign rem_w = {rem_r[31:0], sqv_r[61:60]};
  assign trial = {1'b0, root_r, 2'b01};
  assign num   = {1'b0, m_r[comp_r][29:0], 14'b0} + {14'b0, 1'b0, root_r[30:1]};
  assign dt    = {rdiv_r, dlo_r[14]};
  assign q_fin = {q_r[13:0], (dt >= {1'b0, root_r})};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            m_r[0]   <= mag_x;
            m_r[1]   <= mag_y;
            m_r[2]   <= mag_z;
            sgn_r[0] <= sum_x[SUM_W-1];
            sgn_r[1] <= sum_y[SUM_W-1];
            sgn_r[2] <= sum_z[SUM_W-1];
            zero_r   <= 1'b0;
            if (sum_x == '0 && sum_y == '0 && sum_z == '0) begin
              zero_r  <= 1'b1;
              res_r[0] <= '0;
              res_r[1] <= '0;
              res_r[2] <= '0;
              state_r <= N_DONE;
            end else begin
              state_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          // Truncating right shifts compose, so large steps give the same result.
          if (mmax >= (SUM_W'(1) << 34)) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 4;
          end else if (mmax >= (SUM_W'(1) << 30)) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (mmax < (SUM_W'(1) << 25)) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 4;
          end else if (mmax < (SUM_W'(1) << 29)) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            cnt_r   <= '0;
            acc_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          sq_r <= 60'(sq_op * sq_op);
          if (cnt_r != '0) begin
            acc_r <= acc_r + 62'(sq_r);
          end
          if (cnt_r == 5'd3) begin
            sqv_r   <= acc_r + 62'(sq_r);
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= N_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        N_SQRT: begin
          sqv_r <= sqv_r << 2;
          if (rem_w >= trial) begin
            rem_r  <= rem_w - trial;
            root_r <= {root_r[29:0], 1'b1};
          end else begin
            rem_r  <= rem_w;
            root_r <= {root_r[29:0], 1'b0};
          end
          if (cnt_r == 5'd30) begin
            cnt_r   <= '0;
            comp_r  <= '0;
            state_r <= N_DIV;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        N_DIV: begin
          // The quotient never exceeds 2^14, so the top of the dividend
          // already lies below the divisor.
          if (cnt_r == '0) begin
            rdiv_r <= {1'b0, num[44:15]};
            dlo_r  <= num[14:0];
            q_r    <= '0;
            cnt_r  <= 5'd1;
          end else begin
            dlo_r <= dlo_r << 1;
            q_r   <= q_fin;
            if (dt >= {1'b0, root_r}) begin
              rdiv_r <= 31'(dt - {1'b0, root_r});
            end else begin
              rdiv_r <= dt[30:0];
            end
            if (cnt_r == 5'd15) begin
              res_r[comp_r] <= sgn_r[comp_r] ? -nrm_t'({1'b0, q_fin})
                                             : nrm_t'({1'b0, q_fin});
              cnt_r <= '0;
              if (comp_r == 2'd2) begin
                state_r <= N_DONE;
              end else begin
                comp_r <= comp_r + 2'd1;
              end
            end else begin
              cnt_r <= cnt_r + 5'd1;
            end
          end
        end
        N_DONE: begin
          done    <= 1'b1;
          state_r <= N_IDLE;
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign normal_x = res_r[0];
  assign normal_y = res_r[1];
  assign normal_z = res_r[2];
  assign zero_sum = zero_r;

endmodule

// ===== sv/vertex_normal_accumulator.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted smooth vertex normals over positions and sums held in RAM.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_kind .. in_pos_z
//   out     | output    | out_valid, out_ready, out_vertex_id .. out_zero_sum
//
// A load writes its position and clears its vertex sum. A triangle does
// three position reads, six shared 17x17 products and three read-modify-
// writes of the sum RAM, with no writes for a flat face. A read runs the
// block scaling, the bit-serial root and the three 15-step divides, none
// of them for a zero sum. Reset clears only control state; the RAMs are
// not cleared. Input is taken whenever the core is idle, even while a
// result waits in the output register.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator
  import vna_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [IDX_W-1:0]  in_vertex_a,
  input  logic [IDX_W-1:0]  in_vertex_b,
  input  logic [IDX_W-1:0]  in_vertex_c,
  input  coord_t            in_pos_x,
  input  coord_t            in_pos_y,
  input  coord_t            in_pos_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_vertex_id,
  output nrm_t              out_normal_x,
  output nrm_t              out_normal_y,
  output nrm_t              out_normal_z,
  output logic              out_zero_sum
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_TRI_RD = 9'b000000010,
    S_MUL    = 9'b000000100,
    S_SUM_RD = 9'b000001000,
    S_SUM_WR = 9'b000010000,
    S_NRM_RD = 9'b000100000,
    S_NRM_GO = 9'b001000000,
    S_NRM_RUN= 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [3:0]        cnt_r;
  logic [1:0]        corner_r;
  logic [IDX_W-1:0]  va_r, vb_r, vc_r;
  coord_t            px_r [3];
  coord_t            py_r [3];
  coord_t            pz_r [3];
  prod_t             prod_r;
  cross_t            nx_r, ny_r, nz_r;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_id_r;
  nrm_t              out_x_r, out_y_r, out_z_r;
  logic              out_zero_r;

  logic                   in_xfer;
  logic                   pos_we, sum_we;
  logic [ADDR_W-1:0]      pos_raddr, sum_raddr, sum_waddr;
  logic [POS_W-1:0]       pos_rdata;
  logic [3*SUM_W-1:0]     sum_rdata, sum_wdata;
  logic [ADDR_W-1:0]      corner_addr;
  diff_t                  ux, uy, uz, vx, vy, vz;
  diff_t                  op_a, op_b;
  sum_t                   sx_old, sy_old, sz_old;
  logic                   nrm_done, nrm_zero;
  nrm_t                   nrm_x, nrm_y, nrm_z;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------- memories
  assign pos_we = in_xfer && (kind_t'(in_kind) == KIND_LOAD);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    pos_raddr = idx_to_addr(va_r);
      2'd1:    pos_raddr = idx_to_addr(vb_r);
      default: pos_raddr = idx_to_addr(vc_r);
    endcase
  end

  vna_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (idx_to_addr(in_vertex_a)),
    .wdata ({in_pos_z, in_pos_y, in_pos_x}),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  always_comb begin
    case (corner_r)
      2'd0:    corner_addr = idx_to_addr(va_r);
      2'd1:    corner_addr = idx_to_addr(vb_r);
      default: corner_addr = idx_to_addr(vc_r);
    endcase
  end

  assign sx_old = sum_rdata[SUM_W-1:0];
  assign sy_old = sum_rdata[2*SUM_W-1:SUM_W];
  assign sz_old = sum_rdata[3*SUM_W-1:2*SUM_W];

  // Reads and writes of one corner sit in separate cycles, so a repeated
  // corner always sees the freshly written sum.
  always_comb begin
    sum_raddr = (state_r == S_NRM_RD) ? idx_to_addr(va_r) : corner_addr;
    if (state_r == S_SUM_WR) begin
      sum_we    = 1'b1;
      sum_waddr = corner_addr;
      sum_wdata = {sat_add(sz_old, sum_t'(nz_r)),
                   sat_add(sy_old, sum_t'(ny_r)),
                   sat_add(sx_old, sum_t'(nx_r))};
    end else begin
      sum_we    = pos_we;
      sum_waddr = idx_to_addr(in_vertex_a);
      sum_wdata = '0;
    end
  end

  vna_ram #(.WIDTH(3*SUM_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // ------------------------------------------------------------ cross product
  assign ux = diff_t'(px_r[1]) - diff_t'(px_r[0]);
  assign uy = diff_t'(py_r[1]) - diff_t'(py_r[0]);
  assign uz = diff_t'(pz_r[1]) - diff_t'(pz_r[0]);
  assign vx = diff_t'(px_r[2]) - diff_t'(px_r[0]);
  assign vy = diff_t'(py_r[2]) - diff_t'(py_r[0]);
  assign vz = diff_t'(pz_r[2]) - diff_t'(pz_r[0]);

  always_comb begin
    case (cnt_r)
      4'd0:    begin op_a = uy; op_b = vz; end
      4'd1:    begin op_a = uz; op_b = vy; end
      4'd2:    begin op_a = uz; op_b = vx; end
      4'd3:    begin op_a = ux; op_b = vz; end
      4'd4:    begin op_a = ux; op_b = vy; end
      default: begin op_a = uy; op_b = vx; end
    endcase
  end

  // ------------------------------------------------------------- normalizer
  vna_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_NRM_GO),
    .sum_x    (sx_old),
    .sum_y    (sy_old),
    .sum_z    (sz_old),
    .done     (nrm_done),
    .normal_x (nrm_x),
    .normal_y (nrm_y),
    .normal_z (nrm_z),
    .zero_sum (nrm_zero)
  );

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (kind_t'(in_kind))
            KIND_TRI:  state_nxt = S_TRI_RD;
            KIND_READ: state_nxt = S_NRM_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_TRI_RD:  if (cnt_r == 4'd3) state_nxt = S_MUL;
      S_MUL: begin
        if (cnt_r == 4'd7) begin
          state_nxt = (nx_r == '0 && ny_r == '0 && nz_r == '0) ? S_IDLE : S_SUM_RD;
        end
      end
      S_SUM_RD:  state_nxt = S_SUM_WR;
      S_SUM_WR:  state_nxt = (corner_r == 2'd2) ? S_IDLE : S_SUM_RD;
      S_NRM_RD:  state_nxt = S_NRM_GO;
      S_NRM_GO:  state_nxt = S_NRM_RUN;
      S_NRM_RUN: if (nrm_done) state_nxt = S_OUT;
      S_OUT:     if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          cnt_r    <= '0;
          corner_r <= '0;
          if (in_xfer) begin
            va_r <= in_vertex_a;
            vb_r <= in_vertex_b;
            vc_r <= in_vertex_c;
          end
        end
        S_TRI_RD: begin
          // RAM data arrives in the cycle after its address.
          if (cnt_r != '0) begin
            px_r[cnt_r[1:0] - 2'd1] <= pos_rdata[COORD_BITS-1:0];
            py_r[cnt_r[1:0] - 2'd1] <= pos_rdata[2*COORD_BITS-1:COORD_BITS];
            pz_r[cnt_r[1:0] - 2'd1] <= pos_rdata[3*COORD_BITS-1:2*COORD_BITS];
          end
          cnt_r <= (cnt_r == 4'd3) ? 4'd0 : cnt_r + 4'd1;
        end
        S_MUL: begin
          prod_r <= prod_t'(op_a * op_b);
          case (cnt_r)
            4'd0: begin nx_r <= '0; ny_r <= '0; nz_r <= '0; end
            4'd1: nx_r <= nx_r + cross_t'(prod_r);
            4'd2: nx_r <= nx_r - cross_t'(prod_r);
            4'd3: ny_r <= ny_r + cross_t'(prod_r);
            4'd4: ny_r <= ny_r - cross_t'(prod_r);
            4'd5: nz_r <= nz_r + cross_t'(prod_r);
            4'd6: nz_r <= nz_r - cross_t'(prod_r);
            default: ;
          endcase
          cnt_r <= cnt_r + 4'd1;
        end
        S_SUM_WR: corner_r <= corner_r + 2'd1;
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_id_r    <= va_r;
            out_x_r     <= nrm_x;
            out_y_r     <= nrm_y;
            out_z_r     <= nrm_z;
            out_zero_r  <= nrm_zero;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_vertex_id = out_id_r;
  assign out_normal_x  = out_x_r;
  assign out_normal_y  = out_y_r;
  assign out_normal_z  = out_z_r;
  assign out_zero_sum  = out_zero_r;

endmodule

// ===== bench/vertex_normal_accumulator_test.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_test
// Self-checking bench for the vertex normal accumulator. A directed mesh
// covers coordinate extremes, degenerate faces, zero sums and the unused
// kind. Random meshes follow, built only from loaded vertices. A predictor
// keeps its own copy of the positions and sums and checks every read result
// in order, while both handshake sides idle at random.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_test;
  import vna_pkg::*;

  localparam int RANDOM_ITEMS = 1525;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 1500;

  typedef struct {
    kind_t            kind;
    logic [IDX_W-1:0] va;
    logic [IDX_W-1:0] vb;
    logic [IDX_W-1:0] vc;
    coord_t           px;
    coord_t           py;
    coord_t           pz;
  } mesh_op_t;

  typedef struct {
    logic [IDX_W-1:0] vid;
    nrm_t             nx;
    nrm_t             ny;
    nrm_t             nz;
    logic             zero;
  } normal_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [KIND_W-1:0] in_kind = KIND_NONE;
  logic [IDX_W-1:0] in_vertex_a = '0;
  logic [IDX_W-1:0] in_vertex_b = '0;
  logic [IDX_W-1:0] in_vertex_c = '0;
  coord_t           in_pos_x = '0;
  coord_t           in_pos_y = '0;
  coord_t           in_pos_z = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [IDX_W-1:0] out_vertex_id;
  nrm_t             out_normal_x;
  nrm_t             out_normal_y;
  nrm_t             out_normal_z;
  logic             out_zero_sum;

  vertex_normal_accumulator u_dut (.*);

  always #5 clk = ~clk;

  mesh_op_t pending_ops[$];
  normal_t  expected_normals[$];

  // Predictor state.
  coord_t  pos_x_mem[MAX_VERTICES];
  coord_t  pos_y_mem[MAX_VERTICES];
  coord_t  pos_z_mem[MAX_VERTICES];
  longint  sum_x_mem[MAX_VERTICES];
  longint  sum_y_mem[MAX_VERTICES];
  longint  sum_z_mem[MAX_VERTICES];

  int errors = 0;
  int n_loads = 0, n_faces = 0, n_flat = 0, n_reads = 0, n_zero = 0, n_unused = 0;
  int results_seen = 0;
  bit in_fire = 0, out_fire = 0, held = 0;
  int in_gap = 0, out_wait = 0, hold_left = 0, idle_cycles = 0;

  function automatic longint clamp_sum(longint s);
    longint hi;
    hi = (longint'(1) <<< 47) - 1;
    if (s > hi) return hi;
    if (s < -hi - 1) return -hi - 1;
    return s;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic nrm_t unit_part(longint s, longint unsigned m, longint unsigned n);
    longint unsigned q;
    q = (m * 16384 + n / 2) / n;
    if (s < 0) q = -q;
    return q[NRM_W-1:0];
  endfunction

  task automatic queue_op(mesh_op_t op);
    pending_ops = {pending_ops, op};
  endtask

  task automatic predict_normals(mesh_op_t op);
    int ia, ib, ic, k;
    int corner[3];
    longint ux, uy, uz, wx, wy, wz, cx, cy, cz, sx, sy, sz;
    longint unsigned mx, my, mz, mmax, n;
    normal_t res;
    ia = op.va % MAX_VERTICES;
    ib = op.vb % MAX_VERTICES;
    ic = op.vc % MAX_VERTICES;
    case (op.kind)
      KIND_LOAD: begin
        n_loads++;
        pos_x_mem[ia] = op.px;
        pos_y_mem[ia] = op.py;
        pos_z_mem[ia] = op.pz;
        sum_x_mem[ia] = 0;
        sum_y_mem[ia] = 0;
        sum_z_mem[ia] = 0;
      end
      KIND_TRI: begin
        n_faces++;
        ux = longint'(pos_x_mem[ib]) - pos_x_mem[ia];
        uy = longint'(pos_y_mem[ib]) - pos_y_mem[ia];
        uz = longint'(pos_z_mem[ib]) - pos_z_mem[ia];
        wx = longint'(pos_x_mem[ic]) - pos_x_mem[ia];
        wy = longint'(pos_y_mem[ic]) - pos_y_mem[ia];
        wz = longint'(pos_z_mem[ic]) - pos_z_mem[ia];
        cx = uy * wz - uz * wy;
        cy = uz * wx - ux * wz;
        cz = ux * wy - uy * wx;
        if (cx == 0 && cy == 0 && cz == 0) begin
          n_flat++;
        end else begin
          corner[0] = ia; corner[1] = ib; corner[2] = ic;
          for (k = 0; k < 3; k++) begin
            sum_x_mem[corner[k]] = clamp_sum(sum_x_mem[corner[k]] + cx);
            sum_y_mem[corner[k]] = clamp_sum(sum_y_mem[corner[k]] + cy);
            sum_z_mem[corner[k]] = clamp_sum(sum_z_mem[corner[k]] + cz);
          end
        end
      end
      KIND_READ: begin
        n_reads++;
        sx = sum_x_mem[ia]; sy = sum_y_mem[ia]; sz = sum_z_mem[ia];
        mx = sx < 0 ? -sx : sx;
        my = sy < 0 ? -sy : sy;
        mz = sz < 0 ? -sz : sz;
        mmax = mx;
        if (my > mmax) mmax = my;
        if (mz > mmax) mmax = mz;
        res.vid = op.va;
        if (mmax == 0) begin
          n_zero++;
          res.nx = '0; res.ny = '0; res.nz = '0; res.zero = 1'b1;
        end else begin
          while (mmax >= (64'd1 << 30)) begin
            mmax >>= 1; mx >>= 1; my >>= 1; mz >>= 1;
          end
          while (mmax < (64'd1 << 29)) begin
            mmax <<= 1; mx <<= 1; my <<= 1; mz <<= 1;
          end
          n = root_floor(mx * mx + my * my + mz * mz);
          res.nx = unit_part(sx, mx, n);
          res.ny = unit_part(sy, my, n);
          res.nz = unit_part(sz, mz, n);
          res.zero = 1'b0;
        end
        expected_normals = {expected_normals, res};
      end
      default: n_unused++;
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  // Input driver.
  always @(negedge clk) begin
    mesh_op_t op;
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_fire) in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        in_kind <= op.kind;
        in_vertex_a <= op.va;
        in_vertex_b <= op.vb;
        in_vertex_c <= op.vc;
        in_pos_x <= op.px;
        in_pos_y <= op.py;
        in_pos_z <= op.pz;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side ready control, with one long hold-off to back the block up.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) out_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (!held && results_seen == 25) begin
        held = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: every transfer is predicted or checked at the rising edge.
  always @(posedge clk) begin
    mesh_op_t op;
    normal_t want;
    in_fire = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (in_fire) begin
      op.kind = kind_t'(in_kind);
      op.va = in_vertex_a; op.vb = in_vertex_b; op.vc = in_vertex_c;
      op.px = in_pos_x; op.py = in_pos_y; op.pz = in_pos_z;
      predict_normals(op);
    end
    if (out_fire) begin
      results_seen++;
      if (expected_normals.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result for vertex %0d", out_vertex_id);
      end else begin
        want = expected_normals.pop_front();
        if (out_vertex_id !== want.vid) report_mismatch("vertex_id", out_vertex_id, want.vid);
        if (out_normal_x !== want.nx) report_mismatch("normal_x", out_normal_x, want.nx);
        if (out_normal_y !== want.ny) report_mismatch("normal_y", out_normal_y, want.ny);
        if (out_normal_z !== want.nz) report_mismatch("normal_z", out_normal_z, want.nz);
        if (out_zero_sum !== want.zero) report_mismatch("zero_sum", out_zero_sum, want.zero);
      end
    end
    if (in_fire || out_fire || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic mesh_op_t make_op(kind_t k, int a, int b, int c,
                                       int x, int y, int z);
    mesh_op_t op;
    op.kind = k;
    op.va = IDX_W'(a); op.vb = IDX_W'(b); op.vc = IDX_W'(c);
    op.px = coord_t'(x); op.py = coord_t'(y); op.pz = coord_t'(z);
    return op;
  endfunction

  function automatic coord_t rand_coord();
    if ($urandom_range(0, 4) == 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  initial begin
    int loaded[$];
    bit is_loaded[MAX_VERTICES];
    int i, r, a, b, c;
    mesh_op_t op;

    // Directed mesh.
    queue_op(make_op(KIND_LOAD, 0, 1023, 1023, -32768, -32768, -32768));
    queue_op(make_op(KIND_LOAD, 1023, 0, 0, 32767, -32768, 32767));
    queue_op(make_op(KIND_LOAD, 512, 341, 682, -32768, 32767, 32767));
    queue_op(make_op(KIND_LOAD, 5, 0, 0, 256, 512, 0));
    queue_op(make_op(KIND_LOAD, 6, 0, 0, 512, 1024, 0));
    queue_op(make_op(KIND_LOAD, 7, 0, 0, 768, 1536, 0));
    queue_op(make_op(KIND_READ, 5, 0, 0, 0, 0, 0));
    queue_op(make_op(KIND_TRI, 0, 1023, 512, 0, 0, 0));
    queue_op(make_op(KIND_TRI, 512, 0, 1023, -1, -1, -1));
    queue_op(make_op(KIND_TRI, 0, 0, 1023, 0, 0, 0));
    queue_op(make_op(KIND_TRI, 5, 5, 5, 0, 0, 0));
    // Collinear corners: a flat face.
    queue_op(make_op(KIND_TRI, 5, 6, 7, 0, 0, 0));
    queue_op(make_op(KIND_NONE, 1023, 1023, 1023, -1, -1, -1));
    queue_op(make_op(KIND_READ, 0, 1023, 1023, 0, 0, 0));
    queue_op(make_op(KIND_READ, 1023, 0, 0, 0, 0, 0));
    queue_op(make_op(KIND_READ, 512, 0, 0, 0, 0, 0));
    queue_op(make_op(KIND_READ, 6, 0, 0, 0, 0, 0));
    queue_op(make_op(KIND_LOAD, 0, 0, 0, 0, 0, 0));
    queue_op(make_op(KIND_READ, 0, 0, 0, 0, 0, 0));
    foreach (is_loaded[j]) is_loaded[j] = 0;
    foreach (pending_ops[j]) begin
      if (pending_ops[j].kind == KIND_LOAD && !is_loaded[pending_ops[j].va]) begin
        is_loaded[pending_ops[j].va] = 1;
        loaded = {loaded, int'(pending_ops[j].va)};
      end
    end

    // Random meshes: faces and reads only touch loaded vertices.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      op.vb = IDX_W'($urandom_range(0, 1023));
      op.vc = IDX_W'($urandom_range(0, 1023));
      op.px = coord_t'($urandom);
      op.py = coord_t'($urandom);
      op.pz = coord_t'($urandom);
      if (r < 25 || loaded.size() < 8) begin
        op.kind = KIND_LOAD;
        a = (r < 8) ? loaded[$urandom_range(0, loaded.size() - 1)] : $urandom_range(0, 1023);
        op.va = IDX_W'(a);
        op.px = rand_coord(); op.py = rand_coord(); op.pz = rand_coord();
        if (!is_loaded[a]) begin
          is_loaded[a] = 1;
          loaded = {loaded, a};
        end
      end else if (r < 75) begin
        op.kind = KIND_TRI;
        a = loaded[$urandom_range(0, loaded.size() - 1)];
        b = loaded[$urandom_range(0, loaded.size() - 1)];
        c = loaded[$urandom_range(0, loaded.size() - 1)];
        op.va = IDX_W'(a); op.vb = IDX_W'(b); op.vc = IDX_W'(c);
      end else if (r < 96) begin
        op.kind = KIND_READ;
        op.va = IDX_W'(loaded[$urandom_range(0, loaded.size() - 1)]);
      end else begin
        op.kind = KIND_NONE;
        op.va = IDX_W'($urandom_range(0, 1023));
      end
      queue_op(op);
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    wait (pending_ops.size() == 0 && !in_valid);
    wait (expected_normals.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d loads, %0d faces (%0d flat), %0d unused items.",
             n_loads, n_faces, n_flat, n_unused);
    $display("Checked %0d normals, %0d of them zero sums; %0d mismatches.",
             results_seen, n_zero, errors);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
